FILE: src/assert_macros.svh
// assertion macros used by the top level rtl file of the shape function block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define FSFE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define FSFE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: src/fsfe_pkg.sv
// package: widths, element kinds and stage types of the shape function pipeline
`default_nettype none

package fsfe_pkg;

  localparam int COORD_FRAC_BITS = 14;
  localparam int COORD_W = 16;
  localparam int NODE_W = 3;
  localparam int KIND_W = 3;
  localparam int OUT_W = 20;

  // one +/- coordinate, exact
  localparam int TERM_W =
    ((COORD_FRAC_BITS + 2 > COORD_W) ? COORD_FRAC_BITS + 2 : COORD_W) + 1;
  // one - x - y - z, exact
  localparam int LIN_W = TERM_W + 1;
  localparam int PROD_W = 2 * TERM_W;
  // product of two terms rounded to the fraction bits
  localparam int AB_W = PROD_W + 1 - COORD_FRAC_BITS;
  localparam int ABC_W = AB_W + TERM_W;
  // unclipped results, wide enough for every family
  localparam int RAW_W = OUT_W + 4;

  localparam logic signed [RAW_W-1:0] RAW_ONE = RAW_W'(1) << COORD_FRAC_BITS;
  localparam logic signed [RAW_W-1:0] RAW_HALF = RAW_W'(1) << (COORD_FRAC_BITS - 1);
  localparam logic signed [RAW_W-1:0] RAW_OUT_MAX = RAW_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [RAW_W-1:0] RAW_OUT_MIN = ~RAW_OUT_MAX;

  typedef enum logic [KIND_W-1:0] {
    KIND_INTERVAL = 3'd0,
    KIND_TRIANGLE = 3'd1,
    KIND_QUAD     = 3'd2,
    KIND_TET      = 3'd3,
    KIND_HEX      = 3'd4
  } elem_kind_t;

  typedef struct packed {
    logic [NODE_W-1:0]         node_sel;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
  } fsfe_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] shape_value;
    logic signed [OUT_W-1:0] grad_x;
    logic signed [OUT_W-1:0] grad_y;
    logic signed [OUT_W-1:0] grad_z;
    logic                    node_error;
    logic                    saturated;
  } fsfe_out_t;

  // after term formation
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [NODE_W-1:0]        node;
    logic                     err;
    logic                     sx;
    logic                     sy;
    logic                     sz;
    logic signed [TERM_W-1:0] a;
    logic signed [TERM_W-1:0] b;
    logic signed [TERM_W-1:0] c;
    logic signed [LIN_W-1:0]  lin;
  } fsfe_s1_t;

  // after the pairwise products
  typedef struct packed {
    fsfe_s1_t                 s1;
    logic signed [PROD_W-1:0] p_ab;
    logic signed [PROD_W-1:0] p_bc;
    logic signed [PROD_W-1:0] p_ac;
  } fsfe_s2_t;

  // after rounding and family select
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic                     err;
    logic signed [AB_W-1:0]   ab;
    logic signed [TERM_W-1:0] c;
    logic signed [RAW_W-1:0]  v;
    logic signed [RAW_W-1:0]  gx;
    logic signed [RAW_W-1:0]  gy;
    logic signed [RAW_W-1:0]  gz;
  } fsfe_s3_t;

  // after the hexahedron value product
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic                    err;
    logic signed [ABC_W-1:0] p_abc;
    logic signed [RAW_W-1:0] v;
    logic signed [RAW_W-1:0] gx;
    logic signed [RAW_W-1:0] gy;
    logic signed [RAW_W-1:0] gz;
  } fsfe_s4_t;

endpackage

`default_nettype wire

FILE: src/fem_shape_function_eval.sv
// top level: linear lagrange shape function evaluator, five stage pipeline
//
//   port group   dir   carries
//   in_*         in    request: node_sel, coord_x, coord_y, coord_z
//   out_*        out   result: shape_value, grad_x/y/z, node_error, saturated
//   cfg_*        in    element_kind write
//
// one request per cycle while in_ready is high; the two multiplier stages
// are the term products, then the hexahedron value product. reset clears
// the stage valids and sets element_kind to interval. a stalled output
// holds its register while earlier stages keep filling bubbles; in_ready
// drops only when every stage is full.
`default_nettype none

`include "assert_macros.svh"

module fem_shape_function_eval (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fsfe_pkg::fsfe_in_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output fsfe_pkg::fsfe_out_t           out_data,
  input  logic                          cfg_we,
  input  logic [fsfe_pkg::KIND_W-1:0]   cfg_wdata
);
  import fsfe_pkg::*;

  localparam int NSTAGE = 5;

  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [NSTAGE-1:0] vld_r, vld_nxt;
  logic [NSTAGE-1:0] rdy;
  fsfe_s1_t          s1;
  fsfe_s2_t          s2;
  fsfe_s3_t          s3;
  logic              err_dirty;

  assign kind_nxt = cfg_we ? cfg_wdata : kind_r;

  // a stage takes new data when empty or when its content moves on
  always_comb begin
    rdy[NSTAGE-1] = !vld_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_INTERVAL;
      vld_r <= '0;
    end else begin
      kind_r <= kind_nxt;
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = rdy[0];
  assign out_valid = vld_r[NSTAGE-1];

  fsfe_prep u_prep (
    .clk  (clk),
    .en   (rdy[0]),
    .kind (kind_r),
    .req  (in_data),
    .s1_r (s1)
  );

  fsfe_mul u_mul (
    .clk  (clk),
    .en   (rdy[1]),
    .s1   (s1),
    .s2_r (s2)
  );

  fsfe_round u_round (
    .clk  (clk),
    .en   (rdy[2]),
    .s2   (s2),
    .s3_r (s3)
  );

  fsfe_final u_final (
    .clk    (clk),
    .en_mul (rdy[3]),
    .en_out (rdy[4]),
    .s3     (s3),
    .res_r  (out_data)
  );

  assign err_dirty = out_data.saturated || (out_data.shape_value != '0) ||
                     (out_data.grad_x != '0) || (out_data.grad_y != '0) ||
                     (out_data.grad_z != '0);

  `FSFE_ASSERT(a_full_when_blocked, !in_ready |-> (&vld_r) && !out_ready, "stall with free stage")
  `FSFE_ASSERT(a_accept_lands, in_valid && in_ready |=> vld_r[0], "accepted request lost at entry")
  `FSFE_NEVER(a_err_clean, out_valid && out_data.node_error && err_dirty, "nonzero error result")

endmodule

`default_nettype wire

FILE: src/fsfe_prep.sv
// stage 1: node decode, node count check, linear terms and simplex values
`default_nettype none

module fsfe_prep (
  input  logic                          clk,
  input  logic                          en,
  input  logic [fsfe_pkg::KIND_W-1:0]   kind,
  input  fsfe_pkg::fsfe_in_t            req,
  output fsfe_pkg::fsfe_s1_t            s1_r
);
  import fsfe_pkg::*;

  localparam int CNT_W = NODE_W + 1;
  localparam logic signed [TERM_W-1:0] ONE_T = TERM_W'(1) << COORD_FRAC_BITS;
  localparam logic signed [LIN_W-1:0] ONE_L = LIN_W'(1) << COORD_FRAC_BITS;

  fsfe_s1_t                 s1_nxt;
  logic [CNT_W-1:0]         cnt;
  logic signed [TERM_W-1:0] x_t, y_t, z_t;
  logic signed [LIN_W-1:0]  x_l, y_l, z_l, z_used;

  assign x_t = TERM_W'($signed(req.coord_x));
  assign y_t = TERM_W'($signed(req.coord_y));
  assign z_t = TERM_W'($signed(req.coord_z));
  assign x_l = LIN_W'($signed(req.coord_x));
  assign y_l = LIN_W'($signed(req.coord_y));
  assign z_l = LIN_W'($signed(req.coord_z));
  assign z_used = (kind == KIND_TET) ? z_l : '0;

  always_comb begin
    unique case (kind)
      KIND_INTERVAL: cnt = CNT_W'(2);
      KIND_TRIANGLE: cnt = CNT_W'(3);
      KIND_QUAD:     cnt = CNT_W'(4);
      KIND_TET:      cnt = CNT_W'(4);
      KIND_HEX:      cnt = CNT_W'(8);
      default:       cnt = '0;
    endcase
  end

  always_comb begin
    s1_nxt.kind = kind;
    s1_nxt.node = req.node_sel;
    s1_nxt.err = {1'b0, req.node_sel} >= cnt;
    // quad nodes run counterclockwise, so +x is node 1 or 2
    s1_nxt.sx = (kind == KIND_QUAD) ? (req.node_sel[0] ^ req.node_sel[1])
                                    : req.node_sel[0];
    s1_nxt.sy = req.node_sel[1];
    s1_nxt.sz = req.node_sel[2];
    s1_nxt.a = s1_nxt.sx ? ONE_T + x_t : ONE_T - x_t;
    s1_nxt.b = s1_nxt.sy ? ONE_T + y_t : ONE_T - y_t;
    s1_nxt.c = s1_nxt.sz ? ONE_T + z_t : ONE_T - z_t;
    case (req.node_sel)
      3'd0:    s1_nxt.lin = ONE_L - x_l - y_l - z_used;
      3'd1:    s1_nxt.lin = x_l;
      3'd2:    s1_nxt.lin = y_l;
      default: s1_nxt.lin = z_l;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/fsfe_mul.sv
// stage 2: the three pairwise products of the linear terms
`default_nettype none

module fsfe_mul (
  input  logic                clk,
  input  logic                en,
  input  fsfe_pkg::fsfe_s1_t  s1,
  output fsfe_pkg::fsfe_s2_t  s2_r
);
  import fsfe_pkg::*;

  fsfe_s2_t                 s2_nxt;
  logic signed [TERM_W-1:0] a, b, c;
  logic signed [PROD_W-1:0] p_ab, p_bc, p_ac;

  assign a = s1.a;
  assign b = s1.b;
  assign c = s1.c;
  assign p_ab = a * b;
  assign p_bc = b * c;
  assign p_ac = a * c;

  always_comb begin
    s2_nxt.s1 = s1;
    s2_nxt.p_ab = p_ab;
    s2_nxt.p_bc = p_bc;
    s2_nxt.p_ac = p_ac;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/fsfe_round.sv
// stage 3: signed rounding of the products and per-family result select
`default_nettype none

module fsfe_round (
  input  logic                clk,
  input  logic                en,
  input  fsfe_pkg::fsfe_s2_t  s2,
  output fsfe_pkg::fsfe_s3_t  s3_r
);
  import fsfe_pkg::*;

  localparam int F = COORD_FRAC_BITS;
  localparam logic signed [PROD_W:0] H_F  = (PROD_W + 1)'(1) << (F - 1);
  localparam logic signed [PROD_W:0] H_F2 = (PROD_W + 1)'(1) << (F + 1);
  localparam logic signed [PROD_W:0] H_F3 = (PROD_W + 1)'(1) << (F + 2);
  localparam logic signed [TERM_W:0] H_1 = (TERM_W + 1)'(1);
  localparam logic signed [TERM_W:0] H_2 = (TERM_W + 1)'(2);

  fsfe_s3_t                 s3_nxt;
  fsfe_s1_t                 m;
  logic signed [PROD_W-1:0] p_ab, p_bc, p_ac;
  logic signed [PROD_W:0]   p_ab_e, p_bc_e, p_ac_e;
  logic signed [PROD_W:0]   t_ab, t_qv, t_hx, t_hy, t_hz;
  logic signed [TERM_W-1:0] a, b;
  logic signed [TERM_W:0]   a_e, b_e, t_iv, t_qx, t_qy;
  logic signed [RAW_W-1:0]  iv, qv, qx, qy, hx, hy, hz, lin;
  logic signed [RAW_W-1:0]  sg_x, sg_y, sg_z;

  assign m = s2.s1;
  assign p_ab = s2.p_ab;
  assign p_bc = s2.p_bc;
  assign p_ac = s2.p_ac;
  assign p_ab_e = (PROD_W + 1)'(p_ab);
  assign p_bc_e = (PROD_W + 1)'(p_bc);
  assign p_ac_e = (PROD_W + 1)'(p_ac);
  assign a = m.a;
  assign b = m.b;
  assign a_e = (TERM_W + 1)'(a);
  assign b_e = (TERM_W + 1)'(b);

  // round to nearest, ties up: add half then floor shift; sign folded into the add
  assign t_ab = p_ab_e + H_F;
  assign t_qv = p_ab_e + H_F2;
  assign t_hx = m.sx ? p_bc_e + H_F3 : H_F3 - p_bc_e;
  assign t_hy = m.sy ? p_ac_e + H_F3 : H_F3 - p_ac_e;
  assign t_hz = m.sz ? p_ab_e + H_F3 : H_F3 - p_ab_e;
  assign t_iv = a_e + H_1;
  assign t_qx = m.sx ? b_e + H_2 : H_2 - b_e;
  assign t_qy = m.sy ? a_e + H_2 : H_2 - a_e;

  assign iv = RAW_W'($signed(t_iv[TERM_W:1]));
  assign qv = RAW_W'($signed(t_qv[PROD_W:F+2]));
  assign qx = RAW_W'($signed(t_qx[TERM_W:2]));
  assign qy = RAW_W'($signed(t_qy[TERM_W:2]));
  assign hx = RAW_W'($signed(t_hx[PROD_W:F+3]));
  assign hy = RAW_W'($signed(t_hy[PROD_W:F+3]));
  assign hz = RAW_W'($signed(t_hz[PROD_W:F+3]));
  assign lin = RAW_W'(m.lin);

  // constant gradients of the simplex families
  always_comb begin
    sg_x = '0;
    sg_y = '0;
    sg_z = '0;
    case (m.node)
      3'd0: begin
        sg_x = -RAW_ONE;
        sg_y = -RAW_ONE;
        sg_z = -RAW_ONE;
      end
      3'd1: sg_x = RAW_ONE;
      3'd2: sg_y = RAW_ONE;
      3'd3: sg_z = RAW_ONE;
      default: sg_x = '0;
    endcase
  end

  always_comb begin
    s3_nxt.kind = m.kind;
    s3_nxt.err = m.err;
    s3_nxt.ab = t_ab[PROD_W:F];
    s3_nxt.c = m.c;
    s3_nxt.v = '0;
    s3_nxt.gx = '0;
    s3_nxt.gy = '0;
    s3_nxt.gz = '0;
    unique case (m.kind)
      KIND_INTERVAL: begin
        s3_nxt.v = iv;
        s3_nxt.gx = m.sx ? RAW_HALF : -RAW_HALF;
      end
      KIND_TRIANGLE: begin
        s3_nxt.v = lin;
        s3_nxt.gx = sg_x;
        s3_nxt.gy = sg_y;
      end
      KIND_QUAD: begin
        s3_nxt.v = qv;
        s3_nxt.gx = qx;
        s3_nxt.gy = qy;
      end
      KIND_TET: begin
        s3_nxt.v = lin;
        s3_nxt.gx = sg_x;
        s3_nxt.gy = sg_y;
        s3_nxt.gz = sg_z;
      end
      KIND_HEX: begin
        // value comes from the next product
        s3_nxt.gx = hx;
        s3_nxt.gy = hy;
        s3_nxt.gz = hz;
      end
      default: s3_nxt.v = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: src/fsfe_final.sv
// stages 4 and 5: hexahedron value product, final rounding, clipping, result register
`default_nettype none

module fsfe_final (
  input  logic                clk,
  input  logic                en_mul,
  input  logic                en_out,
  input  fsfe_pkg::fsfe_s3_t  s3,
  output fsfe_pkg::fsfe_out_t res_r
);
  import fsfe_pkg::*;

  localparam int F = COORD_FRAC_BITS;
  localparam logic signed [ABC_W:0] H_F3 = (ABC_W + 1)'(1) << (F + 2);

  fsfe_s4_t                 s4_r, s4_nxt;
  fsfe_out_t                res_nxt;
  logic signed [AB_W-1:0]   ab;
  logic signed [TERM_W-1:0] c;
  logic signed [ABC_W-1:0]  p_abc;
  logic signed [ABC_W:0]    p_abc_e, t_hv;
  logic signed [RAW_W-1:0]  v_raw, gx_raw, gy_raw, gz_raw;

  function automatic logic signed [OUT_W-1:0] clip(input logic signed [RAW_W-1:0] val);
    logic signed [RAW_W-1:0] lim;
    begin
      lim = val;
      if (val > RAW_OUT_MAX) begin
        lim = RAW_OUT_MAX;
      end else if (val < RAW_OUT_MIN) begin
        lim = RAW_OUT_MIN;
      end
      clip = lim[OUT_W-1:0];
    end
  endfunction

  function automatic logic over(input logic signed [RAW_W-1:0] val);
    over = (val > RAW_OUT_MAX) || (val < RAW_OUT_MIN);
  endfunction

  assign ab = s3.ab;
  assign c = s3.c;
  assign p_abc = ab * c;

  always_comb begin
    s4_nxt.kind = s3.kind;
    s4_nxt.err = s3.err;
    s4_nxt.p_abc = p_abc;
    s4_nxt.v = s3.v;
    s4_nxt.gx = s3.gx;
    s4_nxt.gy = s3.gy;
    s4_nxt.gz = s3.gz;
  end

  always_ff @(posedge clk) begin
    if (en_mul) begin
      s4_r <= s4_nxt;
    end
  end

  assign p_abc_e = (ABC_W + 1)'(s4_r.p_abc);
  assign t_hv = p_abc_e + H_F3;
  assign v_raw = (s4_r.kind == KIND_HEX) ? RAW_W'($signed(t_hv[ABC_W:F+3])) : s4_r.v;
  assign gx_raw = s4_r.gx;
  assign gy_raw = s4_r.gy;
  assign gz_raw = s4_r.gz;

  always_comb begin
    res_nxt.node_error = s4_r.err;
    if (s4_r.err) begin
      res_nxt.shape_value = '0;
      res_nxt.grad_x = '0;
      res_nxt.grad_y = '0;
      res_nxt.grad_z = '0;
      res_nxt.saturated = 1'b0;
    end else begin
      res_nxt.shape_value = clip(v_raw);
      res_nxt.grad_x = clip(gx_raw);
      res_nxt.grad_y = clip(gy_raw);
      res_nxt.grad_z = clip(gz_raw);
      res_nxt.saturated = over(v_raw) || over(gx_raw) || over(gy_raw) || over(gz_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire
